// ===== rtl/twdtw_pkg.sv =====
// shared widths, codes and helpers of the time weighted dtw cost block
`timescale 1ns / 1ps
package twdtw_pkg;

  localparam int unsigned BAND_W     = 16;
  localparam int unsigned DAY_W      = 9;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned THETA_W    = 17;
  localparam int unsigned PLEN_W     = 7;
  localparam int unsigned SLEN_W     = 9;
  localparam int unsigned DIFF_W     = 17;
  localparam int unsigned SQ_W       = 34;
  localparam int unsigned SUMSQ_W    = 36;
  localparam int unsigned ROOT_W     = 34;
  localparam int unsigned REM_W      = 40;
  localparam int unsigned SHIFT_W    = 64;
  localparam int unsigned STEP_W     = 6;
  localparam int unsigned PROD1_W    = 51;
  localparam int unsigned PROD2_W    = 33;
  localparam int unsigned LOCAL_W    = 36;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned PATH_W     = 56;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [STEP_W-1:0]  SQRT_LAST = 6'd47;
  localparam logic [THETA_W-1:0] THETA_ONE = 17'd65536;
  localparam logic [ACC_W-1:0]   ACC_CAP   = 48'hFFFF_FFFF_FFFF;
  localparam logic [PATH_W-1:0]  SUM_CAP   = 56'hFF_FFFF_FFFF_FFFF;

  localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_PATTERN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_SERIES  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_START        = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_THETA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEN  = 2'd2;

  localparam logic [1:0] PICK_DIAG = 2'd0;
  localparam logic [1:0] PICK_UP   = 2'd1;
  localparam logic [1:0] PICK_LEFT = 2'd2;

  function automatic logic [1:0] pick3(input logic [ACC_W-1:0] diag,
                                       input logic [ACC_W-1:0] up,
                                       input logic [ACC_W-1:0] left);
    logic [1:0] k;
    if (diag <= up && diag <= left) begin
      k = PICK_DIAG;
    end else if (up <= left) begin
      k = PICK_UP;
    end else begin
      k = PICK_LEFT;
    end
    return k;
  endfunction

endpackage

// ===== rtl/twdtw_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module twdtw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/time_weighted_dtw_cost.sv =====
// time weighted dtw cost: loads, matrix fill and traceback
//
// Items arrive on the s_axis channel; tuser carries the command (load weight,
// load pattern point, load series point, start). Loads are written to their
// memory on the transaction and are accepted back to back while idle.
// A start fills the accumulated cost matrix one cell at a time in row-major
// order. Each cell takes a fetch from the point memories, one squared band
// difference per cycle, a 48-step restoring square root and two multiplies
// for the time weight mix, then the write of the cell.
// The traceback then reads three neighbours per step from the single matrix
// read port in the check, up and left states, at most pattern + series steps.
// One result leaves on m_axis per start (tdata path cost, tuser saturation).
// While a start is in progress s_axis_tready is low. If the receiver stalls
// the result waits in the output register and the block takes more loads;
// a further start holds its result until the earlier one is taken.
// The config channel is always ready; the user must write it only while idle,
// which the block does not enforce. Reset sets theta to one half and the
// lengths to their maxima; memory contents are undefined until loaded.
`timescale 1ns / 1ps
module time_weighted_dtw_cost #(
  parameter int unsigned MAX_PATTERN_LEN = 64,
  parameter int unsigned MAX_SERIES_LEN  = 256,
  parameter int unsigned BANDS           = 4,
  parameter int unsigned DAY_SPAN        = 512
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // index, day, weight, band_0, band_1, band_2, band_3, zero pad
  input  logic [twdtw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd
  input  logic [twdtw_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // path_cost
  output logic [twdtw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // saturated
  output logic [0:0]                           m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [twdtw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [twdtw_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned PIW   = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int unsigned SIW   = (MAX_SERIES_LEN > 1) ? $clog2(MAX_SERIES_LEN) : 1;
  localparam int unsigned WAW   = $clog2(DAY_SPAN);
  localparam int unsigned MDEPTH = MAX_PATTERN_LEN * MAX_SERIES_LEN;
  localparam int unsigned MAW   = $clog2(MDEPTH);
  localparam int unsigned PT_W  = BANDS * twdtw_pkg::BAND_W + twdtw_pkg::DAY_W;
  localparam int unsigned BW    = (BANDS > 1) ? $clog2(BANDS) : 1;

  localparam logic [PIW-1:0] P_LAST = PIW'(MAX_PATTERN_LEN - 1);
  localparam logic [SIW-1:0] S_LAST = SIW'(MAX_SERIES_LEN - 1);
  localparam logic [MAW-1:0] ROW    = MAW'(MAX_SERIES_LEN);
  localparam logic [WAW-1:0] W_LAST = WAW'(DAY_SPAN - 1);
  localparam logic [BW-1:0]  B_LAST = BW'(BANDS - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FETCH = 4'd1;
  localparam logic [3:0] ST_DIFF  = 4'd2;
  localparam logic [3:0] ST_SQ    = 4'd3;
  localparam logic [3:0] ST_SQRT  = 4'd4;
  localparam logic [3:0] ST_MUL1  = 4'd5;
  localparam logic [3:0] ST_MUL2  = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_TCHK  = 4'd8;
  localparam logic [3:0] ST_TUP   = 4'd9;
  localparam logic [3:0] ST_TLEFT = 4'd10;
  localparam logic [3:0] ST_TPICK = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  // input fields
  logic [twdtw_pkg::IDX_W-1:0]    in_index;
  logic [twdtw_pkg::DAY_W-1:0]    in_day;
  logic [twdtw_pkg::WEIGHT_W-1:0] in_weight;
  logic [twdtw_pkg::CMD_W-1:0]    in_cmd;
  logic [PT_W-1:0]                in_point;
  logic                           in_fire;

  assign in_index  = s_axis_tdata[8:0];
  assign in_day    = s_axis_tdata[17:9];
  assign in_weight = s_axis_tdata[33:18];
  assign in_cmd    = s_axis_tuser;

  for (genvar b = 0; b < BANDS; b++) begin : g_band
    if (b < 4) begin : g_real
      assign in_point[b*twdtw_pkg::BAND_W +: twdtw_pkg::BAND_W] =
        s_axis_tdata[34 + b*16 +: 16];
    end else begin : g_zero
      assign in_point[b*twdtw_pkg::BAND_W +: twdtw_pkg::BAND_W] = '0;
    end
  end
  assign in_point[PT_W-1 -: twdtw_pkg::DAY_W] = in_day;

  // registers
  logic [3:0]                        state_q, state_d;
  logic [twdtw_pkg::THETA_W-1:0]     theta_q;
  logic [twdtw_pkg::PLEN_W-1:0]      plen_q;
  logic [twdtw_pkg::SLEN_W-1:0]      slen_q;
  logic [twdtw_pkg::THETA_W-1:0]     th_q;
  logic [PIW-1:0]                    n_last_q, i_q;
  logic [SIW-1:0]                    m_last_q, j_q;
  logic [MAW-1:0]                    cur_q, row_base_q;
  logic [BW-1:0]                     bcnt_q;
  logic [twdtw_pkg::SUMSQ_W-1:0]     sumsq_q;
  logic [twdtw_pkg::SHIFT_W-1:0]     sh_q;
  logic [twdtw_pkg::REM_W-1:0]       rem_q;
  logic [twdtw_pkg::ROOT_W-1:0]      root_q;
  logic [twdtw_pkg::STEP_W-1:0]      step_q;
  logic [twdtw_pkg::WEIGHT_W-1:0]    w_q;
  logic [twdtw_pkg::PROD1_W-1:0]     p1_q;
  logic [twdtw_pkg::PROD2_W-1:0]     p2_q;
  logic [twdtw_pkg::ACC_W-1:0]       diag_q, up_q, left_q;
  logic [twdtw_pkg::PATH_W-1:0]      sum_q;
  logic                              sat_q;
  logic                              out_valid_q;
  logic [twdtw_pkg::PATH_W-1:0]      out_cost_q;
  logic                              out_sat_q;

  // memories
  logic                              wt_we, pt_we, sr_we, mx_we;
  logic [WAW-1:0]                    wt_raddr;
  logic [twdtw_pkg::WEIGHT_W-1:0]    wt_rdata;
  logic [PT_W-1:0]                   pt_rdata, sr_rdata;
  logic [MAW-1:0]                    mx_raddr;
  logic [twdtw_pkg::ACC_W-1:0]       mx_rdata, cell_val;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign wt_we = in_fire && in_cmd == twdtw_pkg::CMD_LOAD_WEIGHT && 32'(in_index) < DAY_SPAN;
  assign pt_we = in_fire && in_cmd == twdtw_pkg::CMD_LOAD_PATTERN &&
                 32'(in_index) < MAX_PATTERN_LEN;
  assign sr_we = in_fire && in_cmd == twdtw_pkg::CMD_LOAD_SERIES &&
                 32'(in_index) < MAX_SERIES_LEN;
  assign mx_we = state_q == ST_ACC;

  twdtw_ram #(.WIDTH(twdtw_pkg::WEIGHT_W), .DEPTH(DAY_SPAN)) u_weight_ram (
    .clk_i, .we_i(wt_we), .waddr_i(WAW'(in_index)), .wdata_i(in_weight),
    .raddr_i(wt_raddr), .rdata_o(wt_rdata)
  );

  twdtw_ram #(.WIDTH(PT_W), .DEPTH(MAX_PATTERN_LEN)) u_pattern_ram (
    .clk_i, .we_i(pt_we), .waddr_i(PIW'(in_index)), .wdata_i(in_point),
    .raddr_i(i_q), .rdata_o(pt_rdata)
  );

  twdtw_ram #(.WIDTH(PT_W), .DEPTH(MAX_SERIES_LEN)) u_series_ram (
    .clk_i, .we_i(sr_we), .waddr_i(SIW'(in_index)), .wdata_i(in_point),
    .raddr_i(j_q), .rdata_o(sr_rdata)
  );

  twdtw_ram #(.WIDTH(twdtw_pkg::ACC_W), .DEPTH(MDEPTH)) u_matrix_ram (
    .clk_i, .we_i(mx_we), .waddr_i(cur_q), .wdata_i(cell_val),
    .raddr_i(mx_raddr), .rdata_o(mx_rdata)
  );

  // day difference to weight address
  logic [twdtw_pkg::DAY_W-1:0] pday, sday, dday;
  always_comb begin
    pday = pt_rdata[PT_W-1 -: twdtw_pkg::DAY_W];
    sday = sr_rdata[PT_W-1 -: twdtw_pkg::DAY_W];
    dday = (pday > sday) ? pday - sday : sday - pday;
    wt_raddr = (32'(dday) >= DAY_SPAN) ? W_LAST : WAW'(dday);
  end

  // matrix read address
  always_comb begin
    case (state_q)
      ST_TCHK:  mx_raddr = cur_q - ROW - MAW'(1);
      ST_TUP:   mx_raddr = cur_q - ROW;
      ST_TLEFT: mx_raddr = cur_q - MAW'(1);
      default:  mx_raddr = cur_q - ROW;
    endcase
  end

  // squared band difference
  logic signed [twdtw_pkg::DIFF_W-1:0] bdiff;
  logic [twdtw_pkg::DIFF_W-1:0]        babs;
  logic [twdtw_pkg::SQ_W-1:0]          bsq;
  logic [twdtw_pkg::BAND_W-1:0]        pband, sband;
  always_comb begin
    pband = pt_rdata[bcnt_q*twdtw_pkg::BAND_W +: twdtw_pkg::BAND_W];
    sband = sr_rdata[bcnt_q*twdtw_pkg::BAND_W +: twdtw_pkg::BAND_W];
    bdiff = $signed({pband[twdtw_pkg::BAND_W-1], pband}) -
            $signed({sband[twdtw_pkg::BAND_W-1], sband});
    babs  = bdiff[twdtw_pkg::DIFF_W-1] ? twdtw_pkg::DIFF_W'(-bdiff)
                                       : twdtw_pkg::DIFF_W'(bdiff);
    bsq   = twdtw_pkg::SQ_W'(babs) * twdtw_pkg::SQ_W'(babs);
  end

  // square root step
  logic [twdtw_pkg::REM_W-1:0] rem_sh, trial;
  always_comb begin
    rem_sh = {rem_q[twdtw_pkg::REM_W-3:0], sh_q[twdtw_pkg::SHIFT_W-1 -: 2]};
    trial  = twdtw_pkg::REM_W'({root_q, 2'b01});
  end

  // cell value
  logic [twdtw_pkg::LOCAL_W-1:0] local_c;
  logic [twdtw_pkg::ACC_W-1:0]   base;
  logic [twdtw_pkg::ACC_W:0]     cell_sum;
  logic                          cell_sat;
  logic [twdtw_pkg::PROD1_W:0]   mix;
  always_comb begin
    mix     = (twdtw_pkg::PROD1_W+1)'(p1_q) + (twdtw_pkg::PROD1_W+1)'(p2_q);
    local_c = mix[twdtw_pkg::PROD1_W:16];
    if (i_q == '0) begin
      base = '0;
    end else if (j_q == '0) begin
      base = up_q;
    end else begin
      case (twdtw_pkg::pick3(diag_q, up_q, left_q))
        twdtw_pkg::PICK_DIAG: base = diag_q;
        twdtw_pkg::PICK_UP:   base = up_q;
        default:              base = left_q;
      endcase
    end
    cell_sum = (twdtw_pkg::ACC_W+1)'(local_c) + (twdtw_pkg::ACC_W+1)'(base);
    cell_sat = cell_sum >= (twdtw_pkg::ACC_W+1)'(twdtw_pkg::ACC_CAP);
    cell_val = cell_sat ? twdtw_pkg::ACC_CAP : cell_sum[twdtw_pkg::ACC_W-1:0];
  end

  // traceback step
  logic [1:0]                    tpick;
  logic [twdtw_pkg::ACC_W-1:0]   tval;
  logic [twdtw_pkg::PATH_W:0]    tsum;
  logic                          tsat;
  always_comb begin
    tpick = twdtw_pkg::pick3(diag_q, up_q, mx_rdata);
    case (tpick)
      twdtw_pkg::PICK_DIAG: tval = diag_q;
      twdtw_pkg::PICK_UP:   tval = up_q;
      default:              tval = mx_rdata;
    endcase
    tsum = {1'b0, sum_q} + (twdtw_pkg::PATH_W+1)'(tval);
    tsat = tsum >= (twdtw_pkg::PATH_W+1)'(twdtw_pkg::SUM_CAP);
  end

  logic cell_last;
  assign cell_last = (i_q == n_last_q) && (j_q == m_last_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire && in_cmd == twdtw_pkg::CMD_START) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SQ;
      ST_SQ:    if (bcnt_q == B_LAST) state_d = ST_SQRT;
      ST_SQRT:  if (step_q == twdtw_pkg::SQRT_LAST) state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_ACC;
      ST_ACC:   state_d = cell_last ? ST_TCHK : ST_FETCH;
      ST_TCHK:  state_d = (i_q == '0 || j_q == '0) ? ST_DONE : ST_TUP;
      ST_TUP:   state_d = ST_TLEFT;
      ST_TLEFT: state_d = ST_TPICK;
      ST_TPICK: state_d = ST_TCHK;
      ST_DONE:  if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      theta_q     <= 17'd32768;
      plen_q      <= 7'd64;
      slen_q      <= 9'd256;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          twdtw_pkg::CFG_THETA: theta_q <= cfg_data_i;
          twdtw_pkg::CFG_PLEN:  plen_q  <= cfg_data_i[twdtw_pkg::PLEN_W-1:0];
          twdtw_pkg::CFG_SLEN:  slen_q  <= cfg_data_i[twdtw_pkg::SLEN_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        th_q       <= (theta_q > twdtw_pkg::THETA_ONE) ? twdtw_pkg::THETA_ONE : theta_q;
        n_last_q   <= (plen_q == '0) ? '0 :
                      (32'(plen_q) > MAX_PATTERN_LEN) ? P_LAST : PIW'(plen_q - 7'd1);
        m_last_q   <= (slen_q == '0) ? '0 :
                      (32'(slen_q) > MAX_SERIES_LEN) ? S_LAST : SIW'(slen_q - 9'd1);
        i_q        <= '0;
        j_q        <= '0;
        cur_q      <= '0;
        row_base_q <= '0;
        sat_q      <= 1'b0;
        sum_q      <= '0;
      end
      ST_DIFF: begin
        diag_q  <= up_q;
        up_q    <= mx_rdata;
        sumsq_q <= '0;
        bcnt_q  <= '0;
      end
      ST_SQ: begin
        if (bcnt_q == '0) begin
          w_q <= wt_rdata;
        end
        sumsq_q <= sumsq_q + twdtw_pkg::SUMSQ_W'(bsq);
        bcnt_q  <= bcnt_q + BW'(1);
        sh_q    <= twdtw_pkg::SHIFT_W'(sumsq_q + twdtw_pkg::SUMSQ_W'(bsq));
        rem_q   <= '0;
        root_q  <= '0;
        step_q  <= '0;
      end
      ST_SQRT: begin
        sh_q   <= {sh_q[twdtw_pkg::SHIFT_W-3:0], 2'b00};
        step_q <= step_q + twdtw_pkg::STEP_W'(1);
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[twdtw_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[twdtw_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      ST_MUL1: p1_q <= twdtw_pkg::PROD1_W'(twdtw_pkg::THETA_ONE - th_q) *
                       twdtw_pkg::PROD1_W'(root_q);
      ST_MUL2: p2_q <= twdtw_pkg::PROD2_W'(th_q) * twdtw_pkg::PROD2_W'(w_q);
      ST_ACC: begin
        left_q <= cell_val;
        if (cell_sat) sat_q <= 1'b1;
        if (!cell_last) begin
          if (j_q == m_last_q) begin
            j_q        <= '0;
            i_q        <= i_q + PIW'(1);
            cur_q      <= row_base_q + ROW;
            row_base_q <= row_base_q + ROW;
          end else begin
            j_q   <= j_q + SIW'(1);
            cur_q <= cur_q + MAW'(1);
          end
        end
      end
      ST_TUP:   diag_q <= mx_rdata;
      ST_TLEFT: up_q   <= mx_rdata;
      ST_TPICK: begin
        case (tpick)
          twdtw_pkg::PICK_DIAG: begin
            i_q   <= i_q - PIW'(1);
            j_q   <= j_q - SIW'(1);
            cur_q <= cur_q - ROW - MAW'(1);
          end
          twdtw_pkg::PICK_UP: begin
            i_q   <= i_q - PIW'(1);
            cur_q <= cur_q - ROW;
          end
          default: begin
            j_q   <= j_q - SIW'(1);
            cur_q <= cur_q - MAW'(1);
          end
        endcase
        if (tsat) begin
          sum_q <= twdtw_pkg::SUM_CAP;
          sat_q <= 1'b1;
        end else begin
          sum_q <= tsum[twdtw_pkg::PATH_W-1:0];
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_cost_q <= sum_q;
          out_sat_q  <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_cost_q;
  assign m_axis_tuser  = out_sat_q;

endmodule

// ===== bench/time_weighted_dtw_cost_tb.sv =====
// testbench of the time weighted dtw cost block: table loads, starts and path cost checks
`timescale 1ns / 1ps
module time_weighted_dtw_cost_tb;

  localparam int PAT_MAX = 64;
  localparam int SER_MAX = 256;
  localparam int SPAN    = 512;

  typedef struct {
    logic [twdtw_pkg::CMD_W-1:0]    cmd;
    logic [twdtw_pkg::IDX_W-1:0]    idx;
    logic [twdtw_pkg::DAY_W-1:0]    day;
    logic [twdtw_pkg::WEIGHT_W-1:0] weight;
    logic [twdtw_pkg::BAND_W-1:0]   band [4];
  } point_item_t;

  typedef struct packed {
    logic [twdtw_pkg::PATH_W-1:0] cost;
    logic                         sat;
  } path_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [twdtw_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [twdtw_pkg::CMD_W-1:0]      s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [twdtw_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]                       m_axis_tuser;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [twdtw_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [twdtw_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  time_weighted_dtw_cost dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the block state
  logic [twdtw_pkg::WEIGHT_W-1:0]    weight_mem [SPAN];
  logic signed [twdtw_pkg::BAND_W-1:0] pat_band [PAT_MAX][4];
  logic [twdtw_pkg::DAY_W-1:0]       pat_day [PAT_MAX];
  logic signed [twdtw_pkg::BAND_W-1:0] ser_band [SER_MAX][4];
  logic [twdtw_pkg::DAY_W-1:0]       ser_day [SER_MAX];
  logic [twdtw_pkg::ACC_W-1:0]       acc_cells [PAT_MAX][SER_MAX];
  logic [twdtw_pkg::THETA_W-1:0]     theta_reg = 17'd32768;
  logic [twdtw_pkg::PLEN_W-1:0]      plen_reg = 7'd64;
  logic [twdtw_pkg::SLEN_W-1:0]      slen_reg = 9'd256;

  path_result_t expected_paths [$];
  int errors = 0;
  int loads_sent = 0;
  int starts_sent = 0;
  int paths_checked = 0;
  int burst_left = 0;
  int biggest_cells = 0;

  function automatic logic [47:0] root_q16(input logic [35:0] s);
    logic [95:0] x;
    logic [47:0] r;
    logic [47:0] t;
    x = {60'd0, s} << 32;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      t = r | (48'd1 << b);
      if ({48'd0, t} * {48'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] cell_cost(input int i, input int j);
    logic [35:0] s;
    logic signed [16:0] d;
    logic [twdtw_pkg::DAY_W-1:0] dd;
    logic [95:0] mix;
    logic [16:0] th;
    s = '0;
    for (int b = 0; b < 4; b++) begin
      d = 17'(pat_band[i][b]) - 17'(ser_band[j][b]);
      if (d < 0) d = -d;
      s += 36'(d) * 36'(d);
    end
    dd = (pat_day[i] > ser_day[j]) ? pat_day[i] - ser_day[j] : ser_day[j] - pat_day[i];
    th = (theta_reg > twdtw_pkg::THETA_ONE) ? twdtw_pkg::THETA_ONE : theta_reg;
    mix = 96'(17'd65536 - th) * 96'(root_q16(s)) + 96'(th) * 96'(weight_mem[dd]);
    return 64'(mix >> 16);
  endfunction

  function automatic logic [twdtw_pkg::ACC_W-1:0] acc_sum(input logic [63:0] a,
                                                          input logic [63:0] b,
                                                          inout logic sat);
    logic [63:0] r;
    r = a + b;
    if (r >= 64'(twdtw_pkg::ACC_CAP)) begin
      sat = 1'b1;
      r = 64'(twdtw_pkg::ACC_CAP);
    end
    return r[twdtw_pkg::ACC_W-1:0];
  endfunction

  function automatic int cheapest_step(input logic [twdtw_pkg::ACC_W-1:0] d,
                                       input logic [twdtw_pkg::ACC_W-1:0] u,
                                       input logic [twdtw_pkg::ACC_W-1:0] l);
    if (d <= u && d <= l) return 0;
    if (u <= l) return 1;
    return 2;
  endfunction

  function automatic path_result_t warp_path_cost();
    path_result_t res;
    int n, m, i, j, k;
    logic sat;
    logic [63:0] sum;
    logic [twdtw_pkg::ACC_W-1:0] best;
    n = (plen_reg == 0) ? 1 : (plen_reg > PAT_MAX) ? PAT_MAX : plen_reg;
    m = (slen_reg == 0) ? 1 : (slen_reg > SER_MAX) ? SER_MAX : slen_reg;
    if (n * m > biggest_cells) biggest_cells = n * m;
    sat = 1'b0;
    sum = '0;
    for (j = 0; j < m; j++) acc_cells[0][j] = acc_sum(cell_cost(0, j), 0, sat);
    for (i = 1; i < n; i++) acc_cells[i][0] = acc_sum(cell_cost(i, 0), acc_cells[i-1][0], sat);
    for (i = 1; i < n; i++) begin
      for (j = 1; j < m; j++) begin
        k = cheapest_step(acc_cells[i-1][j-1], acc_cells[i-1][j], acc_cells[i][j-1]);
        best = (k == 0) ? acc_cells[i-1][j-1] : (k == 1) ? acc_cells[i-1][j] : acc_cells[i][j-1];
        acc_cells[i][j] = acc_sum(cell_cost(i, j), best, sat);
      end
    end
    i = n - 1;
    j = m - 1;
    while (i > 0 && j > 0) begin
      k = cheapest_step(acc_cells[i-1][j-1], acc_cells[i-1][j], acc_cells[i][j-1]);
      if (k != 2) i--;
      if (k != 1) j--;
      sum += acc_cells[i][j];
      if (sum >= 64'(twdtw_pkg::SUM_CAP)) begin
        sum = 64'(twdtw_pkg::SUM_CAP);
        sat = 1'b1;
      end
    end
    res.cost = sum[twdtw_pkg::PATH_W-1:0];
    res.sat = sat;
    return res;
  endfunction

  function automatic void apply_item(input point_item_t it);
    case (it.cmd)
      twdtw_pkg::CMD_LOAD_WEIGHT: weight_mem[it.idx] = it.weight;
      twdtw_pkg::CMD_LOAD_PATTERN: if (it.idx < PAT_MAX) begin
        pat_day[it.idx] = it.day;
        for (int b = 0; b < 4; b++) pat_band[it.idx][b] = it.band[b];
      end
      twdtw_pkg::CMD_LOAD_SERIES: if (it.idx < SER_MAX) begin
        ser_day[it.idx] = it.day;
        for (int b = 0; b < 4; b++) ser_band[it.idx][b] = it.band[b];
      end
      default: expected_paths.insert(expected_paths.size(), warp_path_cost());
    endcase
  endfunction

  task automatic send_item(input point_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {6'd0, it.band[3], it.band[2], it.band[1], it.band[0],
                      it.weight, it.day, it.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_item(it);
    if (it.cmd == twdtw_pkg::CMD_START) starts_sent++;
    else loads_sent++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_paths.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [twdtw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [twdtw_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      twdtw_pkg::CFG_THETA: theta_reg = val;
      twdtw_pkg::CFG_PLEN:  plen_reg = val[twdtw_pkg::PLEN_W-1:0];
      default:              slen_reg = val[twdtw_pkg::SLEN_W-1:0];
    endcase
  endtask

  function automatic point_item_t random_point(input logic [twdtw_pkg::CMD_W-1:0] cmd,
                                               input int idx);
    point_item_t it;
    it.cmd = cmd;
    it.idx = twdtw_pkg::IDX_W'(idx);
    it.day = ($urandom_range(0, 7) == 0) ? twdtw_pkg::DAY_W'($urandom_range(0, 511))
                                         : twdtw_pkg::DAY_W'($urandom_range(0, 366));
    it.weight = twdtw_pkg::WEIGHT_W'($urandom);
    for (int b = 0; b < 4; b++) it.band[b] = twdtw_pkg::BAND_W'($urandom);
    return it;
  endfunction

  task automatic start_run(input int n, input int m);
    point_item_t it;
    write_reg(twdtw_pkg::CFG_PLEN, twdtw_pkg::CFG_DATA_W'(n));
    write_reg(twdtw_pkg::CFG_SLEN, twdtw_pkg::CFG_DATA_W'(m));
    it = random_point(twdtw_pkg::CMD_START, $urandom_range(0, 511));
    send_item(it);
  endtask

  task automatic test_table_fill();
    for (int k = 0; k < SPAN; k++) begin
      send_item(random_point(twdtw_pkg::CMD_LOAD_WEIGHT, k));
    end
    for (int k = 0; k < PAT_MAX; k++) send_item(random_point(twdtw_pkg::CMD_LOAD_PATTERN, k));
    for (int k = 0; k < SER_MAX; k++) send_item(random_point(twdtw_pkg::CMD_LOAD_SERIES, k));
  endtask

  task automatic test_corner_cases();
    point_item_t it;
    // widest band distance and widest day gap
    it = random_point(twdtw_pkg::CMD_LOAD_PATTERN, 0);
    it.day = 9'd0;
    for (int b = 0; b < 4; b++) it.band[b] = 16'h7FFF;
    send_item(it);
    it.cmd = twdtw_pkg::CMD_LOAD_SERIES;
    it.day = 9'd511;
    for (int b = 0; b < 4; b++) it.band[b] = 16'h8000;
    send_item(it);
    it.idx = 9'd1;
    it.day = 9'd0;
    send_item(it);
    it = random_point(twdtw_pkg::CMD_LOAD_WEIGHT, 511);
    it.weight = 16'hFFFF;
    send_item(it);
    it.idx = 9'd0;
    it.weight = 16'h0000;
    send_item(it);
    // ignored loads beyond the point stores
    send_item(random_point(twdtw_pkg::CMD_LOAD_PATTERN, 64));
    send_item(random_point(twdtw_pkg::CMD_LOAD_PATTERN, 511));
    send_item(random_point(twdtw_pkg::CMD_LOAD_SERIES, 256));
    send_item(random_point(twdtw_pkg::CMD_LOAD_SERIES, 511));
    write_reg(twdtw_pkg::CFG_THETA, 17'd0);
    start_run(2, 2);
    write_reg(twdtw_pkg::CFG_THETA, 17'd65536);
    start_run(2, 3);
    write_reg(twdtw_pkg::CFG_THETA, 17'h1FFFF);
    start_run(3, 2);
    write_reg(twdtw_pkg::CFG_THETA, 17'd32768);
    start_run(1, 7);
    start_run(7, 1);
    start_run(0, 0);
    start_run(127, 3);
    start_run(2, 511);
    start_run(64, 4);
    start_run(3, 256);
  endtask

  task automatic test_random_runs();
    int n, m, loads;
    int idx;
    int kind;
    while (loads_sent + starts_sent < 900) begin
      case ($urandom_range(0, 5))
        0: write_reg(twdtw_pkg::CFG_THETA, 17'd0);
        1: write_reg(twdtw_pkg::CFG_THETA, 17'd65536);
        2: write_reg(twdtw_pkg::CFG_THETA, 17'($urandom_range(65537, 131071)));
        default: write_reg(twdtw_pkg::CFG_THETA, 17'($urandom_range(0, 65536)));
      endcase
      loads = $urandom_range(0, 6);
      for (int k = 0; k < loads; k++) begin
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
          send_item(random_point(twdtw_pkg::CMD_LOAD_WEIGHT, $urandom_range(0, 511)));
        end else if (kind < 5) begin
          idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 7);
          send_item(random_point(twdtw_pkg::CMD_LOAD_PATTERN, idx));
        end else begin
          idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 11);
          send_item(random_point(twdtw_pkg::CMD_LOAD_SERIES, idx));
        end
      end
      case ($urandom_range(0, 19))
        0: begin n = $urandom_range(8, 64); m = $urandom_range(1, 3); end
        1: begin n = $urandom_range(1, 2); m = $urandom_range(12, 256); end
        2: begin n = $urandom_range(65, 127); m = $urandom_range(0, 2); end
        default: begin n = $urandom_range(1, 8); m = $urandom_range(1, 12); end
      endcase
      start_run(n, m);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result receiver with its own stall pattern
  int stall_mode = 0;
  int stall_count = 0;
  always @(posedge clk_i) begin
    path_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_paths.size() == 0) begin
        report_mismatch("unexpected result", 64'(m_axis_tdata), '0);
      end else begin
        want = expected_paths.pop_front();
        paths_checked++;
        if (m_axis_tdata !== want.cost) begin
          report_mismatch("path_cost", 64'(m_axis_tdata), 64'(want.cost));
        end
        if (m_axis_tuser[0] !== want.sat) begin
          report_mismatch("saturated", 64'(m_axis_tuser), 64'(want.sat));
        end
      end
    end
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_count <= $urandom_range(20, 400);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= (stall_count % 8 == 0);
    endcase
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_fill();
    test_corner_cases();
    test_random_runs();
    wait_idle();
    repeat (200) @(posedge clk_i);
    $display("covered %0d loads and %0d starts, %0d path costs checked",
             loads_sent, starts_sent, paths_checked);
    $display("largest matrix %0d cells, theta extremes and clamped lengths included",
             biggest_cells);
    if (errors == 0 && expected_paths.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
